FILE: hw/rtl/elvd_pkg.sv
// Package for the edge log varint decoder.
// Holds action codes, field widths and record format constants.
// No dependencies.
`timescale 1ns / 1ps

package elvd_pkg;

   // Fixed field widths of the item channels.
   localparam int ACTION_BITS  = 2;
   localparam int LEVEL_COUNT  = 16;
   localparam int BYTE_BITS    = 8;
   localparam int NUMBER_BITS  = 4;
   localparam int VALUE_BITS   = 64;
   localparam int REL_BITS     = 64;
   localparam int COUNT_BITS   = 5;
   localparam int SHIFT_BITS   = 7;
   localparam int SEL_BITS     = 3;

   typedef logic [ACTION_BITS-1:0] action_type;

   // Action codes carried by an input item.
   localparam action_type ACT_START      = 2'd0;
   localparam action_type ACT_BEGIN_READ = 2'd1;
   localparam action_type ACT_BYTE       = 2'd2;

   // Record byte format: seven payload bits and a continuation flag.
   localparam logic [6:0]            GROUP_MASK = 7'h7F;
   localparam int                    MORE_BIT   = 7;
   localparam logic [SHIFT_BITS-1:0] GROUP_STEP = 7'd7;
   localparam logic [SHIFT_BITS-1:0] SHIFT_CAP  = 7'd70;
   localparam logic [SHIFT_BITS-1:0] SHIFT_END  = 7'd64;

endpackage

FILE: hw/rtl/edge_log_varint_decoder_top.sv
// Top level of the edge log varint decoder: a two stage pipeline.
// Depends on elvd_pkg for action codes and record format constants.
`timescale 1ns / 1ps

// Usage
// The req_ channel carries one item per handshake: a start (base time and
// initial levels), a begin read (current time) or one encoded log byte.
// The rsp_ channel returns one item for each completed record that is read
// while not halted: either a reported edge or a deferred marker.
// csr_write_enable with csr_write_data sets the signal count; write it only
// while the block is idle.
// Flow: an accepted item is held in the accumulate stage register and moves
// through the time stage into the result register once that register can
// take it. The block takes one item per cycle while the receiver does not
// stall.
// When the receiver stalls, the result register holds its item and the
// input register still takes an item if it is empty; once it holds one, req_ready drops.
// Reset clears the partial record, times and levels, sets the signal count
// to one and leaves the block halted until the first begin read.
module edge_log_varint_decoder_top #(
   parameter int MAX_SIGNALS = 16,
   parameter int TIME_BITS   = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  elvd_pkg::action_type                 req_action,
   input  logic [TIME_BITS-1:0]                 req_time_value,
   input  logic [elvd_pkg::LEVEL_COUNT-1:0]     req_level_bits,
   input  logic [elvd_pkg::BYTE_BITS-1:0]       req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [elvd_pkg::NUMBER_BITS-1:0]     rsp_signal_number,
   output logic signed [elvd_pkg::REL_BITS-1:0] rsp_relative_time,
   output logic                                 rsp_falling_edge,
   output logic                                 rsp_deferred,
   input  logic                                 csr_write_enable,
   input  logic [elvd_pkg::COUNT_BITS-1:0]      csr_write_data
);
   import elvd_pkg::*;

   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_SIGNALS);

   // Configuration: number of low value bits that hold the signal number.
   logic [SEL_BITS-1:0]   sel_bits_ff;
   logic [SEL_BITS-1:0]   sel_bits_in;
   logic [COUNT_BITS-1:0] count_clamped;

   // Accumulate stage state and its output register.
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic [SHIFT_BITS-1:0]  shift_ff, shift_in;
   logic                   a_valid_ff;
   action_type             a_action_ff;
   logic [TIME_BITS-1:0]   a_time_ff;
   logic [LEVEL_COUNT-1:0] a_levels_ff;
   logic                   a_complete_ff, a_complete_in;
   logic [TIME_BITS-1:0]   a_delay_ff, a_delay_in;
   logic [NUMBER_BITS-1:0] a_num_ff, a_num_in;

   // Time stage state.
   logic [TIME_BITS-1:0]   running_ff, running_in;
   logic [TIME_BITS-1:0]   latched_ff, latched_in;
   logic [LEVEL_COUNT-1:0] levels_ff, levels_in;
   logic                   halted_ff, halted_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic [REL_BITS-1:0]    rsp_rel_ff, rsp_rel_in;
   logic                   rsp_fall_ff, rsp_fall_in;
   logic                   rsp_def_ff, rsp_def_in;

   logic req_take;
   logic b_go;

   logic [VALUE_BITS-1:0]  acc_merged;
   logic [VALUE_BITS-1:0]  delay_full;
   logic [NUMBER_BITS-1:0] num_mask;
   logic [TIME_BITS:0]     sum_when;
   logic [TIME_BITS+1:0]   sum_diff;
   logic [TIME_BITS+1:0]   diff_wide;
   logic signed [TIME_BITS:0] diff;
   logic                   late;

   // Handshake: the time stage moves when the result register can take a result.
   assign b_go      = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || b_go;
   assign req_take  = req_valid && req_ready;

   // Signal count clamp and number of bits needed for the signal number.
   always_comb begin
      count_clamped = csr_write_data;
      if (count_clamped == '0) begin
         count_clamped = COUNT_BITS'(1);
      end
      if (count_clamped > MAX_COUNT) begin
         count_clamped = MAX_COUNT;
      end
      if (count_clamped <= COUNT_BITS'(1)) begin
         sel_bits_in = SEL_BITS'(0);
      end else if (count_clamped <= COUNT_BITS'(2)) begin
         sel_bits_in = SEL_BITS'(1);
      end else if (count_clamped <= COUNT_BITS'(4)) begin
         sel_bits_in = SEL_BITS'(2);
      end else if (count_clamped <= COUNT_BITS'(8)) begin
         sel_bits_in = SEL_BITS'(3);
      end else begin
         sel_bits_in = SEL_BITS'(4);
      end
   end

   // Accumulate stage: gather 7-bit groups and split a completed value.
   // Bytes are gathered even while halted; the time stage drops those records
   // and any begin read or start clears the partial value first.
   always_comb begin
      acc_merged = acc_ff;
      if (shift_ff < SHIFT_END) begin
         acc_merged = acc_ff
            | (VALUE_BITS'(req_data_byte[6:0] & GROUP_MASK) << shift_ff[5:0]);
      end
      delay_full = acc_merged >> sel_bits_ff;
      a_delay_in = delay_full[TIME_BITS-1:0];
      num_mask   = NUMBER_BITS'((5'd1 << sel_bits_ff) - 5'd1);
      a_num_in   = acc_merged[NUMBER_BITS-1:0] & num_mask;

      acc_in        = acc_ff;
      shift_in      = shift_ff;
      a_complete_in = 1'b0;
      case (req_action)
         ACT_START, ACT_BEGIN_READ: begin
            acc_in   = '0;
            shift_in = '0;
         end
         ACT_BYTE: begin
            if (req_data_byte[MORE_BIT]) begin
               acc_in   = acc_merged;
               shift_in = (shift_ff + GROUP_STEP > SHIFT_CAP) ? SHIFT_CAP
                        : shift_ff + GROUP_STEP;
            end else begin
               acc_in        = '0;
               shift_in      = '0;
               a_complete_in = 1'b1;
            end
         end
         default: begin
            acc_in   = acc_ff;
            shift_in = shift_ff;
         end
      endcase
   end

   // Time stage arithmetic: event time, and its distance to the latched time
   // taken as one three-operand sum with the wrap carry removed at bit TIME_BITS.
   always_comb begin
      sum_when  = {1'b0, running_ff} + {1'b0, a_delay_ff};
      sum_diff  = {2'b00, running_ff} + {2'b00, a_delay_ff} - {2'b00, latched_ff};
      diff_wide = sum_diff - ((TIME_BITS+2)'(sum_when[TIME_BITS]) << TIME_BITS);
      diff      = signed'(diff_wide[TIME_BITS:0]);
      late      = !diff[TIME_BITS] && (diff != '0);
   end

   // Time stage control: start, begin read and completed records.
   always_comb begin
      running_in   = running_ff;
      latched_in   = latched_ff;
      levels_in    = levels_ff;
      halted_in    = halted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_fall_in  = rsp_fall_ff;
      rsp_def_in   = rsp_def_ff;
      if (b_go) begin
         case (a_action_ff)
            ACT_START: begin
               running_in = a_time_ff;
               levels_in  = a_levels_ff;
               halted_in  = 1'b1;
            end
            ACT_BEGIN_READ: begin
               latched_in = a_time_ff;
               halted_in  = 1'b0;
            end
            ACT_BYTE: begin
               if (a_complete_ff && !halted_ff) begin
                  rsp_valid_in = 1'b1;
                  if (late) begin
                     halted_in   = 1'b1;
                     rsp_num_in  = '0;
                     rsp_rel_in  = '0;
                     rsp_fall_in = 1'b0;
                     rsp_def_in  = 1'b1;
                  end else begin
                     running_in           = sum_when[TIME_BITS-1:0];
                     levels_in[a_num_ff]  = !levels_ff[a_num_ff];
                     rsp_num_in           = a_num_ff;
                     rsp_rel_in           = REL_BITS'(diff);
                     rsp_fall_in          = levels_ff[a_num_ff];
                     rsp_def_in           = 1'b0;
                  end
               end
            end
            default: begin
               halted_in = halted_ff;
            end
         endcase
      end
   end

   // State registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_bits_ff  <= '0;
         acc_ff       <= '0;
         shift_ff     <= '0;
         a_valid_ff   <= 1'b0;
         running_ff   <= '0;
         latched_ff   <= '0;
         levels_ff    <= '0;
         halted_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            sel_bits_ff <= sel_bits_in;
         end
         if (req_take) begin
            acc_ff   <= acc_in;
            shift_ff <= shift_in;
         end
         a_valid_ff   <= req_take || (a_valid_ff && !b_go);
         running_ff   <= running_in;
         latched_ff   <= latched_in;
         levels_ff    <= levels_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_action_ff   <= req_action;
         a_time_ff     <= req_time_value;
         a_levels_ff   <= req_level_bits;
         a_complete_ff <= a_complete_in;
         a_delay_ff    <= a_delay_in;
         a_num_ff      <= a_num_in;
      end
      rsp_num_ff  <= rsp_num_in;
      rsp_rel_ff  <= rsp_rel_in;
      rsp_fall_ff <= rsp_fall_in;
      rsp_def_ff  <= rsp_def_in;
   end

   // Result channel.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_signal_number = rsp_num_ff;
   assign rsp_relative_time = signed'(rsp_rel_ff);
   assign rsp_falling_edge  = rsp_fall_ff;
   assign rsp_deferred      = rsp_def_ff;

endmodule
